[rtl/as_pkg.sv]
package as_pkg;

  localparam int CW      = 32;
  localparam int MAG_W   = CW + 1;
  localparam int SUM_W   = 2 * CW + 2;
  localparam int ROOT_W  = CW + 1;
  localparam int SPD_W   = 24;
  localparam int BD_W    = 31;
  localparam int BF_W    = 16;
  localparam int DEN_W   = BD_W + BF_W;
  localparam int U_W     = (SUM_W > DEN_W + 2) ? SUM_W : DEN_W + 2;
  localparam int CNT_W   = $clog2(U_W + 1);
  localparam int OUT_W   = 32;
  localparam int VAL_W   = (CW + 2 > OUT_W + 2) ? CW + 2 : OUT_W + 2;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } as_op_t;

  typedef struct packed {
    logic             start;
    as_op_t           op;
    logic [CNT_W-1:0] steps;
  } as_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } as_rsp_t;

endpackage

[rtl/as_unit.sv]
module as_unit (
  input  logic                     clk,
  input  logic                     rst_n,
  input  as_pkg::as_req_t          req,
  input  logic [as_pkg::U_W-1:0]   opa,
  input  logic [as_pkg::U_W-1:0]   opb,
  input  logic [as_pkg::U_W-1:0]   acc_in,
  output as_pkg::as_rsp_t          rsp,
  output logic [as_pkg::U_W-1:0]   res
);

  logic                         busy_r;
  logic                         done_r;
  as_pkg::as_op_t               op_r;
  logic [as_pkg::CNT_W-1:0]     cnt_r;
  logic [as_pkg::U_W-1:0]       x_r;
  logic [as_pkg::U_W-1:0]       y_r;
  logic [as_pkg::U_W-1:0]       acc_r;
  logic [as_pkg::U_W-1:0]       p;
  logic [as_pkg::U_W-1:0]       q;
  logic                         sub;
  logic [as_pkg::U_W:0]         sum;
  logic                         ge;

  always_comb begin
    unique case (op_r)
      as_pkg::OP_MUL: begin
        p   = acc_r;
        q   = y_r[0] ? x_r : '0;
        sub = 1'b0;
      end
      as_pkg::OP_DIV: begin
        p   = {x_r[as_pkg::U_W-2:0], y_r[as_pkg::U_W-1]};
        q   = opb;
        sub = 1'b1;
      end
      as_pkg::OP_SQRT: begin
        p   = {x_r[as_pkg::U_W-3:0], y_r[as_pkg::U_W-1:as_pkg::U_W-2]};
        q   = {acc_r[as_pkg::U_W-3:0], 2'b01};
        sub = 1'b1;
      end
      default: begin
        p   = '0;
        q   = '0;
        sub = 1'b0;
      end
    endcase
    sum = {1'b0, p} + {1'b0, (sub ? ~q : q)} + {{as_pkg::U_W{1'b0}}, sub};
    ge  = sum[as_pkg::U_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == {{(as_pkg::CNT_W-1){1'b0}}, 1'b1});
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        op_r   <= req.op;
        cnt_r  <= req.steps;
        unique case (req.op)
          as_pkg::OP_MUL: begin
            x_r   <= opa;
            y_r   <= opb;
            acc_r <= acc_in;
          end
          as_pkg::OP_DIV: begin
            x_r   <= opa >> as_pkg::SPD_W;
            y_r   <= opa << (as_pkg::U_W - as_pkg::SPD_W);
            acc_r <= '0;
          end
          as_pkg::OP_SQRT: begin
            x_r   <= '0;
            y_r   <= opa << (as_pkg::U_W - as_pkg::SUM_W);
            acc_r <= '0;
          end
          default: begin
            x_r   <= '0;
            y_r   <= '0;
            acc_r <= '0;
          end
        endcase
      end else if (busy_r) begin
        unique case (op_r)
          as_pkg::OP_MUL: begin
            acc_r <= sum[as_pkg::U_W-1:0];
            x_r   <= x_r << 1;
            y_r   <= y_r >> 1;
          end
          as_pkg::OP_DIV: begin
            x_r   <= ge ? sum[as_pkg::U_W-1:0] : p;
            y_r   <= y_r << 1;
            acc_r <= {acc_r[as_pkg::U_W-2:0], ge};
          end
          as_pkg::OP_SQRT: begin
            x_r   <= ge ? sum[as_pkg::U_W-1:0] : p;
            y_r   <= y_r << 2;
            acc_r <= {acc_r[as_pkg::U_W-2:0], ge};
          end
          default: begin
            acc_r <= acc_r;
          end
        endcase
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == {{(as_pkg::CNT_W-1){1'b0}}, 1'b1}) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign res      = acc_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("done without a running operation");
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("unit busy while reporting done");
  a_busy_no_done: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && cnt_r != {{(as_pkg::CNT_W-1){1'b0}}, 1'b1}) |=> !done_r)
    else $error("done raised early");

endmodule

[rtl/arrival_steering_top.sv]
// Arrival steering: one request carries target, position and velocity; the block returns the
// steering vector and the reached flag. A request normally runs through the single shared
// add/subtract unit, which resolves one bit per cycle through six squarings, two square roots,
// the speed ramp and the three per-axis multiply and divide passes. A request that finds the
// reached flag set skips the unit; one that stops at the target ends after the square roots.
module arrival_steering_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [as_pkg::CW-1:0]  in_target_x,
  input  logic signed [as_pkg::CW-1:0]  in_target_y,
  input  logic signed [as_pkg::CW-1:0]  in_target_z,
  input  logic signed [as_pkg::CW-1:0]  in_position_x,
  input  logic signed [as_pkg::CW-1:0]  in_position_y,
  input  logic signed [as_pkg::CW-1:0]  in_position_z,
  input  logic signed [as_pkg::CW-1:0]  in_velocity_x,
  input  logic signed [as_pkg::CW-1:0]  in_velocity_y,
  input  logic signed [as_pkg::CW-1:0]  in_velocity_z,
  input  logic                          in_clear_reached,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [as_pkg::OUT_W-1:0] out_steer_x,
  output logic signed [as_pkg::OUT_W-1:0] out_steer_y,
  output logic signed [as_pkg::OUT_W-1:0] out_steer_z,
  output logic                          out_reached,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [4:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam logic [2:0] REG_MAX_SPEED  = 3'd0;
  localparam logic [2:0] REG_BRAKE_DIST = 3'd1;
  localparam logic [2:0] REG_BRAKE_FACT = 3'd2;
  localparam logic [2:0] REG_STOP_DIST  = 3'd3;
  localparam logic [2:0] REG_STOP_SPEED = 3'd4;

  localparam int CW    = as_pkg::CW;
  localparam int MAG_W = as_pkg::MAG_W;
  localparam int U_W   = as_pkg::U_W;
  localparam int RW    = as_pkg::ROOT_W;
  localparam int SW    = as_pkg::SPD_W;
  localparam int VW    = as_pkg::VAL_W;
  localparam int OW    = as_pkg::OUT_W;

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_SQRT, S_CHECK, S_RAMP, S_RMUL, S_RDIV, S_AXM, S_AXD, S_FIN
  } state_t;

  state_t                   state_r;
  logic                     go_r;
  logic                     flag_r;
  logic                     phase_r;
  logic [1:0]               idx_r;
  logic [MAG_W-1:0]         diff_r [3];
  logic [CW-1:0]            vel_r [3];
  logic [U_W-1:0]           sum_r;
  logic [RW-1:0]            d_r;
  logic [RW-1:0]            v_r;
  logic [as_pkg::DEN_W-1:0] den_r;
  logic [SW-1:0]            speed_r;
  logic [OW-1:0]            st_r [3];
  logic                     rch_r;
  logic [OW-1:0]            ox_r, oy_r, oz_r;
  logic                     ovalid_r;
  logic                     orch_r;

  logic [23:0]              max_speed_r;
  logic [30:0]              brake_dist_r;
  logic [15:0]              brake_fact_r;
  logic [30:0]              stop_dist_r;
  logic [23:0]              stop_speed_r;

  as_pkg::as_req_t          req;
  as_pkg::as_rsp_t          rsp;
  logic [U_W-1:0]           opa, opb, acc_in, res;

  logic [MAG_W-1:0]         dm_sel, vm_sel, mag_sel, dsel;
  logic [CW-1:0]            vsel;
  logic [RW+7:0]            dsh;
  logic [VW-1:0]            want, val;
  logic [OW-1:0]            steer_val;
  logic                     in_acc, flag_eff, cfg_wr;
  logic [2:0]               cfg_idx;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign flag_eff = flag_r && !in_clear_reached;
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign cfg_idx  = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_speed_r  <= 24'd153600;
      brake_dist_r <= 31'd102400;
      brake_fact_r <= 16'd256;
      stop_dist_r  <= 31'd25600;
      stop_speed_r <= 24'd2560;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MAX_SPEED:  max_speed_r  <= pwdata[23:0];
        REG_BRAKE_DIST: brake_dist_r <= pwdata[30:0];
        REG_BRAKE_FACT: brake_fact_r <= pwdata[15:0];
        REG_STOP_DIST:  stop_dist_r  <= pwdata[30:0];
        REG_STOP_SPEED: stop_speed_r <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_MAX_SPEED:  prdata = {8'd0, max_speed_r};
      REG_BRAKE_DIST: prdata = {1'b0, brake_dist_r};
      REG_BRAKE_FACT: prdata = {16'd0, brake_fact_r};
      REG_STOP_DIST:  prdata = {1'b0, stop_dist_r};
      REG_STOP_SPEED: prdata = {8'd0, stop_speed_r};
      default:        prdata = '0;
    endcase
  end

  always_comb begin
    dsel    = diff_r[idx_r];
    vsel    = vel_r[idx_r];
    dm_sel  = dsel[MAG_W-1] ? (~dsel + 1'b1) : dsel;
    vm_sel  = {1'b0, (vsel[CW-1] ? (~vsel + 1'b1) : vsel)};
    mag_sel = phase_r ? vm_sel : dm_sel;
    dsh     = {d_r, 8'd0};
    want    = dsel[MAG_W-1] ? (~{{(VW-SW){1'b0}}, res[SW-1:0]} + 1'b1)
                            : {{(VW-SW){1'b0}}, res[SW-1:0]};
    if (state_r == S_AXM) begin
      want = '0;
    end
    val = want - {{(VW-CW){vsel[CW-1]}}, vsel};
    if ($signed(val) > $signed({{(VW-OW+1){1'b0}}, {(OW-1){1'b1}}})) begin
      steer_val = {1'b0, {(OW-1){1'b1}}};
    end else if ($signed(val) < $signed({{(VW-OW+1){1'b1}}, {(OW-1){1'b0}}})) begin
      steer_val = {1'b1, {(OW-1){1'b0}}};
    end else begin
      steer_val = val[OW-1:0];
    end
  end

  always_comb begin
    req.start = go_r;
    req.op    = as_pkg::OP_MUL;
    req.steps = as_pkg::CNT_W'(SW);
    opa       = '0;
    opb       = '0;
    acc_in    = '0;
    unique case (state_r)
      S_SQ: begin
        req.steps = as_pkg::CNT_W'(MAG_W);
        opa       = {{(U_W-MAG_W){1'b0}}, mag_sel};
        opb       = {{(U_W-MAG_W){1'b0}}, mag_sel};
        acc_in    = (idx_r == 2'd0) ? '0 : sum_r;
      end
      S_SQRT: begin
        req.op    = as_pkg::OP_SQRT;
        req.steps = as_pkg::CNT_W'(RW);
        opa       = sum_r;
      end
      S_RMUL: begin
        opa = {{(U_W-RW-8){1'b0}}, dsh};
        opb = {{(U_W-24){1'b0}}, max_speed_r};
      end
      S_RDIV: begin
        req.op = as_pkg::OP_DIV;
        opa    = sum_r;
        opb    = {{(U_W-as_pkg::DEN_W){1'b0}}, den_r};
      end
      S_AXM: begin
        opa = {{(U_W-MAG_W){1'b0}}, dm_sel};
        opb = {{(U_W-SW){1'b0}}, speed_r};
      end
      S_AXD: begin
        req.op = as_pkg::OP_DIV;
        opa    = sum_r;
        opb    = {{(U_W-RW){1'b0}}, d_r};
      end
      default: ;
    endcase
  end

  as_unit u_unit (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .opa    (opa),
    .opb    (opb),
    .acc_in (acc_in),
    .rsp    (rsp),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      go_r     <= 1'b0;
      flag_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      if (ovalid_r && out_ready && state_r != S_FIN) begin
        ovalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          go_r <= in_acc && !flag_eff;
          if (in_acc) begin
            flag_r    <= flag_eff;
            diff_r[0] <= {in_target_x[CW-1], in_target_x} - {in_position_x[CW-1], in_position_x};
            diff_r[1] <= {in_target_y[CW-1], in_target_y} - {in_position_y[CW-1], in_position_y};
            diff_r[2] <= {in_target_z[CW-1], in_target_z} - {in_position_z[CW-1], in_position_z};
            vel_r[0]  <= in_velocity_x;
            vel_r[1]  <= in_velocity_y;
            vel_r[2]  <= in_velocity_z;
            idx_r     <= 2'd0;
            phase_r   <= 1'b0;
            for (int i = 0; i < 3; i++) begin
              st_r[i] <= '0;
            end
            rch_r <= 1'b1;
            if (flag_eff) begin
              state_r <= S_FIN;
            end else begin
              state_r <= S_SQ;
            end
          end
        end
        S_SQ: begin
          go_r <= rsp.done;
          if (rsp.done) begin
            sum_r <= res;
            if (idx_r == 2'd2) begin
              state_r <= S_SQRT;
            end else begin
              idx_r <= idx_r + 2'd1;
            end
          end
        end
        S_SQRT: begin
          go_r <= rsp.done && !phase_r;
          if (rsp.done) begin
            idx_r <= 2'd0;
            if (!phase_r) begin
              d_r     <= res[RW-1:0];
              phase_r <= 1'b1;
              state_r <= S_SQ;
            end else begin
              v_r     <= res[RW-1:0];
              state_r <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          go_r  <= 1'b0;
          den_r <= {{(as_pkg::DEN_W-31){1'b0}}, brake_dist_r} *
                   {{(as_pkg::DEN_W-16){1'b0}}, brake_fact_r};
          if ({{(U_W-RW){1'b0}}, d_r} <= {{(U_W-31){1'b0}}, stop_dist_r} &&
              {{(U_W-RW){1'b0}}, v_r} < {{(U_W-24){1'b0}}, stop_speed_r}) begin
            flag_r  <= 1'b1;
            state_r <= S_FIN;
          end else begin
            rch_r   <= 1'b0;
            state_r <= S_RAMP;
          end
        end
        S_RAMP: begin
          if ({{(U_W-RW-8){1'b0}}, dsh} >= {{(U_W-as_pkg::DEN_W){1'b0}}, den_r}) begin
            speed_r <= max_speed_r;
            state_r <= S_AXM;
            go_r    <= (d_r != '0);
          end else begin
            state_r <= S_RMUL;
            go_r    <= 1'b1;
          end
        end
        S_RMUL: begin
          go_r <= rsp.done;
          if (rsp.done) begin
            sum_r   <= res;
            state_r <= S_RDIV;
          end
        end
        S_RDIV: begin
          go_r <= rsp.done && (d_r != '0);
          if (rsp.done) begin
            speed_r <= res[SW-1:0];
            state_r <= S_AXM;
          end
        end
        S_AXM: begin
          go_r <= (d_r != '0) && rsp.done;
          if (d_r == '0) begin
            st_r[idx_r] <= steer_val;
            if (idx_r == 2'd2) begin
              state_r <= S_FIN;
            end else begin
              idx_r <= idx_r + 2'd1;
            end
          end else if (rsp.done) begin
            sum_r   <= res;
            state_r <= S_AXD;
          end
        end
        S_AXD: begin
          go_r <= rsp.done && (idx_r != 2'd2);
          if (rsp.done) begin
            st_r[idx_r] <= steer_val;
            if (idx_r == 2'd2) begin
              state_r <= S_FIN;
            end else begin
              idx_r   <= idx_r + 2'd1;
              state_r <= S_AXM;
            end
          end
        end
        S_FIN: begin
          go_r <= 1'b0;
          if (!ovalid_r || out_ready) begin
            ox_r     <= st_r[0];
            oy_r     <= st_r[1];
            oz_r     <= st_r[2];
            orch_r   <= rch_r;
            ovalid_r <= 1'b1;
            state_r  <= S_IDLE;
          end
        end
        default: begin
          go_r    <= 1'b0;
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid   = ovalid_r;
  assign out_steer_x = ox_r;
  assign out_steer_y = oy_r;
  assign out_steer_z = oz_r;
  assign out_reached = orch_r;

  a_reached_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_reached) |-> (out_steer_x == '0 && out_steer_y == '0 &&
    out_steer_z == '0)) else $error("reached result with non-zero steering");
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready) else $error("second request taken while busy");
  a_start_idle_unit: assert property (@(posedge clk) disable iff (!rst_n)
    go_r |-> !rsp.busy) else $error("unit started while busy");

endmodule

[sim/arrival_steering_top_test.sv]
module arrival_steering_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 600;
  localparam int ITEMS_PER_PHASE = 400;

  typedef enum int {
    REG_MAX_SPEED,
    REG_BRAKING_DISTANCE,
    REG_BRAKING_FACTOR,
    REG_STOP_DISTANCE,
    REG_STOP_SPEED
  } reg_index_t;

  typedef struct {
    logic signed [as_pkg::CW-1:0] tgt[3];
    logic signed [as_pkg::CW-1:0] pos[3];
    logic signed [as_pkg::CW-1:0] vel[3];
    logic clr;
  } agent_request_t;

  typedef struct {
    logic signed [as_pkg::OUT_W-1:0] steer[3];
    logic reached;
  } steer_result_t;

  typedef struct {
    agent_request_t req;
    logic known;
    steer_result_t res;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [as_pkg::CW-1:0] in_tgt[3];
  logic signed [as_pkg::CW-1:0] in_pos[3];
  logic signed [as_pkg::CW-1:0] in_vel[3];
  logic in_clear_reached = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [as_pkg::OUT_W-1:0] out_steer_x, out_steer_y, out_steer_z;
  logic out_reached;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  logic [23:0] max_speed;
  logic [30:0] braking_distance;
  logic [15:0] braking_factor;
  logic [30:0] stop_distance;
  logic [23:0] stop_speed;
  logic reached_flag;

  steer_result_t expected_steer[$];
  directed_row_t directed_rows[$];
  int errors = 0;
  int requests_accepted = 0;
  int idle_cycles = 0;
  bit receiver_hold = 1'b0;
  int burst_left = 0;

  initial begin
    for (int i = 0; i < 3; i++) begin
      in_tgt[i] = '0;
      in_pos[i] = '0;
      in_vel[i] = '0;
    end
  end

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  arrival_steering_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_target_x(in_tgt[0]), .in_target_y(in_tgt[1]), .in_target_z(in_tgt[2]),
    .in_position_x(in_pos[0]), .in_position_y(in_pos[1]), .in_position_z(in_pos[2]),
    .in_velocity_x(in_vel[0]), .in_velocity_y(in_vel[1]), .in_velocity_z(in_vel[2]),
    .in_clear_reached(in_clear_reached),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_steer_x(out_steer_x), .out_steer_y(out_steer_y), .out_steer_z(out_steer_z),
    .out_reached(out_reached),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  function automatic logic [127:0] floor_sqrt(input logic [127:0] n);
    logic [127:0] root, trial;
    root = '0;
    for (int i = 63; i >= 0; i--) begin
      trial = root | (128'd1 << i);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  function automatic logic [31:0] saturate32(input longint x);
    if (x > 64'sd2147483647) return 32'h7FFFFFFF;
    if (x < -64'sd2147483648) return 32'h80000000;
    return x[31:0];
  endfunction

  function automatic steer_result_t arrival_predict(input agent_request_t q);
    steer_result_t res;
    longint diff[3], vel[3], want;
    logic [127:0] dm[3], vm[3], distance, speed_mag, den, speed, quo;
    for (int i = 0; i < 3; i++) res.steer[i] = '0;
    res.reached = 1'b1;
    if (q.clr) reached_flag = 1'b0;
    if (!reached_flag) begin
      for (int i = 0; i < 3; i++) begin
        diff[i] = longint'(q.tgt[i]) - longint'(q.pos[i]);
        vel[i] = longint'(q.vel[i]);
        dm[i] = diff[i] < 0 ? 128'(-diff[i]) : 128'(diff[i]);
        vm[i] = vel[i] < 0 ? 128'(-vel[i]) : 128'(vel[i]);
      end
      distance = floor_sqrt(dm[0] * dm[0] + dm[1] * dm[1] + dm[2] * dm[2]);
      speed_mag = floor_sqrt(vm[0] * vm[0] + vm[1] * vm[1] + vm[2] * vm[2]);
      if (distance <= 128'(stop_distance) && speed_mag < 128'(stop_speed)) begin
        reached_flag = 1'b1;
      end else begin
        den = 128'(braking_distance) * 128'(braking_factor);
        if ((distance << 8) >= den) speed = 128'(max_speed);
        else speed = (128'(max_speed) * (distance << 8)) / den;
        for (int i = 0; i < 3; i++) begin
          want = 0;
          if (distance != 0) begin
            quo = (dm[i] * speed) / distance;
            want = diff[i] < 0 ? -longint'(quo) : longint'(quo);
          end
          res.steer[i] = saturate32(want - vel[i]);
        end
        res.reached = 1'b0;
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    errors++;
  endtask

  task automatic write_register(input reg_index_t idx, input logic [31:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = 5'(int'(idx) * 4);
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    case (idx)
      REG_MAX_SPEED:        max_speed = value[23:0];
      REG_BRAKING_DISTANCE: braking_distance = value[30:0];
      REG_BRAKING_FACTOR:   braking_factor = value[15:0];
      REG_STOP_DISTANCE:    stop_distance = value[30:0];
      REG_STOP_SPEED:       stop_speed = value[23:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [31:0] ms, input logic [31:0] bd, input logic [31:0] bf,
                           input logic [31:0] sd, input logic [31:0] ss);
    write_register(REG_MAX_SPEED, ms);
    write_register(REG_BRAKING_DISTANCE, bd);
    write_register(REG_BRAKING_FACTOR, bf);
    write_register(REG_STOP_DISTANCE, sd);
    write_register(REG_STOP_SPEED, ss);
  endtask

  task automatic send_request(input agent_request_t q, input logic known,
                              input steer_result_t typed);
    steer_result_t predicted;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat ($urandom_range(0, 15)) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid = 1'b1;
    for (int i = 0; i < 3; i++) begin
      in_tgt[i] = q.tgt[i];
      in_pos[i] = q.pos[i];
      in_vel[i] = q.vel[i];
    end
    in_clear_reached = q.clr;
    do @(posedge clk); while (!in_ready);
    requests_accepted++;
    predicted = arrival_predict(q);
    expected_steer.push_back(known ? typed : predicted);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_steer.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic signed [31:0] offset_value();
    return $signed($urandom) >>> $urandom_range(0, 31);
  endfunction

  function automatic agent_request_t random_request();
    agent_request_t q;
    int kind;
    kind = $urandom_range(0, 19);
    for (int i = 0; i < 3; i++) begin
      q.pos[i] = $urandom;
      if (kind < 12) q.tgt[i] = q.pos[i] + offset_value();
      else if (kind < 17) q.tgt[i] = $urandom;
      else if (kind < 19) q.tgt[i] = q.pos[i];
      else q.tgt[i] = $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      q.vel[i] = (kind < 14) ? offset_value() : $signed($urandom);
    end
    q.clr = ($urandom_range(0, 5) == 0);
    return q;
  endfunction

  task automatic add_row(input logic signed [31:0] t[3], input logic signed [31:0] p[3],
                         input logic signed [31:0] v[3], input logic clr, input logic known,
                         input logic signed [31:0] s[3], input logic rch);
    directed_row_t row;
    row.req.tgt = t;
    row.req.pos = p;
    row.req.vel = v;
    row.req.clr = clr;
    row.known = known;
    row.res.steer = s;
    row.res.reached = rch;
    directed_rows.push_back(row);
  endtask

  task automatic build_directed();
    logic signed [31:0] z[3], mx[3], mn[3];
    z = '{0, 0, 0};
    mx = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF};
    mn = '{32'h80000000, 32'h80000000, 32'h80000000};
    add_row(z, z, z, 1'b0, 1'b1, z, 1'b1);
    add_row('{5, -7, 9}, '{-100000, 200000, 3}, mx, 1'b0, 1'b1, z, 1'b1);
    add_row(mx, mn, mn, 1'b1, 1'b0, z, 1'b0);
    add_row(mn, mx, mx, 1'b0, 1'b0, z, 1'b0);
    add_row('{1000, 1000, 1000}, '{1000, 1000, 1000}, '{32'h100000, 32'h100000, 32'h100000},
            1'b0, 1'b1, '{-32'sh100000, -32'sh100000, -32'sh100000}, 1'b0);
    add_row(z, z, mn, 1'b0, 1'b1, mx, 1'b0);
    add_row('{300000, -40000, 7}, z, mx, 1'b0, 1'b0, z, 1'b0);
    add_row('{5000, 0, 0}, z, '{0, 3000, 0}, 1'b0, 1'b0, z, 1'b0);
    add_row('{25600, 0, 0}, z, '{2559, 0, 0}, 1'b0, 1'b1, z, 1'b1);
    add_row('{25600, 0, 0}, z, '{2559, 0, 0}, 1'b1, 1'b1, z, 1'b1);
    add_row('{25600, 0, 0}, z, '{2560, 0, 0}, 1'b1, 1'b0, z, 1'b0);
    add_row('{0, 25601, 0}, z, z, 1'b0, 1'b0, z, 1'b0);
    add_row('{-3000, 4000, -12000}, '{100, -100, 50}, '{-700, 0, 900}, 1'b0, 1'b0, z, 1'b0);
    add_row('{-20000, 0, 0}, z, '{0, 0, -20}, 1'b0, 1'b1, z, 1'b1);
    add_row('{-20000, 0, 0}, z, '{0, 0, -20}, 1'b1, 1'b1, z, 1'b1);
  endtask

  always @(negedge clk) begin
    if (receiver_hold) out_ready = 1'b0;
    else case ((requests_accepted / 150) % 3)
      0: out_ready = 1'b1;
      1: out_ready = $urandom_range(0, 1);
      default: out_ready = ($urandom_range(0, 7) != 0);
    endcase
  end

  initial begin
    wait (requests_accepted >= 300);
    receiver_hold = 1'b1;
    repeat (3000) @(posedge clk);
    receiver_hold = 1'b0;
  end

  always @(posedge clk) begin
    steer_result_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (expected_steer.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        exp_res = expected_steer.pop_front();
        if (out_steer_x !== exp_res.steer[0])
          report_mismatch($sformatf("steer_x %0d, want %0d", out_steer_x, exp_res.steer[0]));
        if (out_steer_y !== exp_res.steer[1])
          report_mismatch($sformatf("steer_y %0d, want %0d", out_steer_y, exp_res.steer[1]));
        if (out_steer_z !== exp_res.steer[2])
          report_mismatch($sformatf("steer_z %0d, want %0d", out_steer_z, exp_res.steer[2]));
        if (out_reached !== exp_res.reached)
          report_mismatch($sformatf("reached %0b, want %0b", out_reached, exp_res.reached));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("arrival_steering_top regression: fail");
      $finish;
    end
  end

  initial begin
    steer_result_t none;
    max_speed = 24'd153600;
    braking_distance = 31'd102400;
    braking_factor = 16'd256;
    stop_distance = 31'd25600;
    stop_speed = 24'd2560;
    reached_flag = 1'b0;
    build_directed();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    foreach (directed_rows[k])
      send_request(directed_rows[k].req, directed_rows[k].known, directed_rows[k].res);
    for (int phase = 0; phase < 5; phase++) begin
      if (phase != 0) begin
        wait_drained();
        case (phase)
          1: configure(32'hFFFFFFFF, 32'hFFFFFFFF, 32'h00000001, 32'hFFFFFFFF, 32'hFFFFFFFF);
          2: configure(32'd0, 32'h7FFFFFFF, 32'h0000FFFF, 32'd0, 32'd0);
          3: configure(32'd153600, 32'd1000, 32'd256, 32'd2560, 32'd2560);
          default: configure($urandom_range(0, 24'hFFFFFF), $urandom_range(1, 32'h00FFFFFF),
                             $urandom_range(1, 16'hFFFF), $urandom_range(0, 32'h00FFFFFF),
                             $urandom_range(0, 24'hFFFF));
        endcase
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_request(random_request(), 1'b0, none);
    end
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_steer.size() == 0) begin
      $display("arrival_steering_top regression: pass");
    end else begin
      $display("arrival_steering_top regression: fail");
    end
    $finish;
  end

endmodule

[arrival_steering_top.f]
rtl/as_pkg.sv
rtl/as_unit.sv
rtl/arrival_steering_top.sv
sim/arrival_steering_top_test.sv
